FILE: rtl/frst_pkg.sv
// shared types, constants and command/status bundles for the fenwick range-sum table
`default_nettype none

package frst_pkg;

	localparam int unsigned MAX_POSITIONS_DEF = 1024;
	localparam int unsigned SIZE_W = 11;
	localparam int unsigned IDX_W = 11;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned SUM_W = 64;
	// width for index range checks, holds MAX_POSITIONS + 1 at the top of its range
	localparam int unsigned CHK_W = 18;
	localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RESET = SIZE_W'(1024);

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_QUERY = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} frst_action_t;

	typedef enum logic [1:0] {
		WALK_ADD = 2'd0,
		WALK_QHI = 2'd1,
		WALK_QLO = 2'd2
	} frst_walk_t;

	typedef struct packed {
		logic       load;
		logic       walk_start;
		frst_walk_t walk_sel;
		logic       walk_step;
		logic       clr_start;
		logic       clr_step;
		logic       out_load;
	} frst_cmd_t;

	typedef struct packed {
		frst_action_t action;
		logic         item_ok;
		logic         walk_live;
		logic         clr_last;
		logic         out_busy;
	} frst_sts_t;

endpackage

`default_nettype wire

FILE: rtl/frst_datapath.sv
// datapath: tree memory, index walker, accumulator, clear sweep and result register
`default_nettype none

module frst_datapath #(
	parameter int unsigned MAX_POSITIONS = frst_pkg::MAX_POSITIONS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [frst_pkg::SIZE_W-1:0]   cfg_wr_data,
	input  wire logic [1:0]                    action,
	input  wire logic [frst_pkg::IDX_W-1:0]    first_index,
	input  wire logic [frst_pkg::IDX_W-1:0]    end_index,
	input  wire logic signed [frst_pkg::VAL_W-1:0] value,
	input  wire frst_pkg::frst_cmd_t           cmd,
	output frst_pkg::frst_sts_t                sts,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [frst_pkg::SUM_W-1:0]  range_total,
	output logic                               index_error
);
	import frst_pkg::*;

	localparam int unsigned ADDR_W = $clog2(MAX_POSITIONS + 1);
	localparam int unsigned WALK_W = ADDR_W + 1;
	localparam int unsigned DEPTH = MAX_POSITIONS + 1;

	logic [SUM_W-1:0] mem [DEPTH];

	logic [SIZE_W-1:0] size_q;
	frst_action_t      action_q;
	logic [IDX_W-1:0]  first_q;
	logic [IDX_W-1:0]  end_q;
	logic [VAL_W-1:0]  value_q;
	logic [WALK_W-1:0] idx_q;
	frst_walk_t        mode_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] addr_s1;
	frst_walk_t        op_s1;
	logic [SUM_W-1:0]  rdata_q;
	logic [SUM_W-1:0]  acc_q;
	logic [ADDR_W-1:0] clr_q;
	logic              out_valid_q;
	logic [SUM_W-1:0]  total_q;
	logic              err_q;

	logic [CHK_W-1:0]  n_chk;
	logic [CHK_W-1:0]  first_chk;
	logic [CHK_W-1:0]  end_chk;
	logic              add_ok;
	logic              query_ok;
	logic              item_ok;
	logic              item_err;
	logic [WALK_W-1:0] n_walk;
	logic [WALK_W-1:0] low_bit;
	logic [WALK_W-1:0] idx_next;
	logic [WALK_W-1:0] start_idx;
	logic              walk_live;
	logic [SUM_W-1:0]  value_ext;

	always_comb begin
		n_chk = (CHK_W'(size_q) > CHK_W'(MAX_POSITIONS)) ? CHK_W'(MAX_POSITIONS)
			: CHK_W'(size_q);
		first_chk = CHK_W'(first_q);
		end_chk = CHK_W'(end_q);
		add_ok = (first_chk != '0) && (first_chk <= n_chk);
		query_ok = (first_chk != '0) && (first_chk <= end_chk)
			&& (end_chk <= n_chk + CHK_W'(1));
		case (action_q)
			ACT_ADD:   item_ok = add_ok;
			ACT_QUERY: item_ok = query_ok;
			default:   item_ok = 1'b1;
		endcase
		item_err = !item_ok;
		n_walk = WALK_W'(n_chk);
		low_bit = idx_q & (~idx_q + WALK_W'(1));
		idx_next = (mode_q == WALK_ADD) ? idx_q + low_bit : idx_q - low_bit;
		// add walks upward and stops past the size, prefix walks stop at zero
		walk_live = (idx_q != '0) && ((mode_q != WALK_ADD) || (idx_q <= n_walk));
		case (cmd.walk_sel)
			WALK_ADD: start_idx = WALK_W'(first_chk);
			WALK_QHI: start_idx = WALK_W'(end_chk - CHK_W'(1));
			WALK_QLO: start_idx = WALK_W'(first_chk - CHK_W'(1));
			default:  start_idx = '0;
		endcase
		value_ext = {{(SUM_W - VAL_W){value_q[VAL_W-1]}}, value_q};
	end

	assign sts.action = action_q;
	assign sts.item_ok = item_ok;
	assign sts.walk_live = walk_live;
	assign sts.clr_last = (clr_q == ADDR_W'(MAX_POSITIONS));
	assign sts.out_busy = out_valid_q && !out_ready;

	// one write port (clear sweep or add update), one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[clr_q] <= '0;
		end else if (pend_s1 && (op_s1 == WALK_ADD)) begin
			mem[addr_s1] <= rdata_q + value_ext;
		end
		if (cmd.walk_step) begin
			rdata_q <= mem[idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= ACTIVE_SIZE_RESET;
			pend_s1 <= 1'b0;
			clr_q <= ADDR_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			pend_s1 <= cmd.walk_step;
			if (cmd.clr_start) begin
				clr_q <= ADDR_W'(1);
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= frst_action_t'(action);
			first_q <= first_index;
			end_q <= end_index;
			value_q <= value;
		end
		if (cmd.walk_start) begin
			idx_q <= start_idx;
			mode_q <= cmd.walk_sel;
		end else if (cmd.walk_step) begin
			idx_q <= idx_next;
		end
		if (cmd.walk_step) begin
			addr_s1 <= idx_q[ADDR_W-1:0];
			op_s1 <= mode_q;
		end
		if (cmd.load) begin
			acc_q <= '0;
		end else if (pend_s1 && (op_s1 == WALK_QHI)) begin
			acc_q <= acc_q + rdata_q;
		end else if (pend_s1 && (op_s1 == WALK_QLO)) begin
			acc_q <= acc_q - rdata_q;
		end
		if (cmd.out_load) begin
			total_q <= acc_q;
			err_q <= item_err;
		end
	end

	assign out_valid = out_valid_q;
	assign range_total = total_q;
	assign index_error = err_q;

endmodule

`default_nettype wire

FILE: rtl/frst_ctrl.sv
// controller state machine: sequences clear sweeps, tree walks and result hand-off
`default_nettype none

module frst_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire frst_pkg::frst_sts_t sts,
	output frst_pkg::frst_cmd_t      cmd
);
	import frst_pkg::*;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_CLEAR,
		S_WALK_ADD,
		S_WALK_QHI,
		S_WALK_QLO,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.action)
					ACT_ADD: begin
						if (sts.item_ok) begin
							cmd.walk_start = 1'b1;
							cmd.walk_sel = WALK_ADD;
							state_d = S_WALK_ADD;
						end else begin
							state_d = S_DONE;
						end
					end
					ACT_QUERY: begin
						if (sts.item_ok) begin
							cmd.walk_start = 1'b1;
							cmd.walk_sel = WALK_QHI;
							state_d = S_WALK_QHI;
						end else begin
							state_d = S_DONE;
						end
					end
					ACT_CLEAR: begin
						cmd.clr_start = 1'b1;
						state_d = S_CLEAR;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_DONE;
				end
			end
			S_WALK_ADD: begin
				if (sts.walk_live) begin
					cmd.walk_step = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_WALK_QHI: begin
				if (sts.walk_live) begin
					cmd.walk_step = 1'b1;
				end else begin
					// second prefix walk is subtracted
					cmd.walk_start = 1'b1;
					cmd.walk_sel = WALK_QLO;
					state_d = S_WALK_QLO;
				end
			end
			S_WALK_QLO: begin
				if (sts.walk_live) begin
					cmd.walk_step = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_step_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> sts.walk_live)
		else $error("walk step issued on a dead index");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result register overwritten before its beat was taken");
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> in_ready)
		else $error("not ready for a new beat after a result was loaded");
`endif

endmodule

`default_nettype wire

FILE: rtl/fenwick_range_sum_table_top.sv
// top level of the fenwick range-sum table: controller plus datapath
// one item at a time, in_ready returns in the cycle after the result is loaded
// add: one upward walk over the tree; query: a prefix walk from the end index less one, then a
// subtracted one from the first index less one; clear: a sweep over entries 1 to MAX_POSITIONS
// reset: async, active low; a clearing pass over entries 1 to MAX_POSITIONS follows with in_ready low
`default_nettype none

module fenwick_range_sum_table_top #(
	parameter int unsigned MAX_POSITIONS = frst_pkg::MAX_POSITIONS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [frst_pkg::SIZE_W-1:0]       cfg_wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        action,
	input  wire logic [frst_pkg::IDX_W-1:0]        first_index,
	input  wire logic [frst_pkg::IDX_W-1:0]        end_index,
	input  wire logic signed [frst_pkg::VAL_W-1:0] value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [frst_pkg::SUM_W-1:0]      range_total,
	output logic                                   index_error
);
	import frst_pkg::*;

	frst_cmd_t cmd;
	frst_sts_t sts;

	frst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	frst_datapath #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.action      (action),
		.first_index (first_index),
		.end_index   (end_index),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.range_total (range_total),
		.index_error (index_error)
	);

endmodule

`default_nettype wire

FILE: sim/tb_fenwick_range_sum_table_top.sv
// testbench for the fenwick range-sum table: directed and random items checked against a local table
`timescale 1ns / 1ps

module tb_fenwick_range_sum_table_top;
	import frst_pkg::*;

	localparam int unsigned POSITIONS = MAX_POSITIONS_DEF;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	typedef struct packed {
		frst_action_t       act;
		logic [IDX_W-1:0]   pos;
		logic [IDX_W-1:0]   end_pos;
		logic signed [31:0] amt;
	} fen_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] total;
		logic             err;
	} sum_result_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [SIZE_W-1:0]       cfg_wr_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              action;
	logic [IDX_W-1:0]        first_index;
	logic [IDX_W-1:0]        end_index;
	logic signed [VAL_W-1:0] value;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [SUM_W-1:0] range_total;
	logic                    index_error;

	// local copy of the tree and the size register
	logic [SUM_W-1:0]  fen_sums [1:POSITIONS];
	logic [SIZE_W-1:0] cur_size;
	sum_result_t       pending_sums [$];
	sum_result_t       exp_sum;

	int unsigned mismatches;
	int unsigned cycles;
	int unsigned tx_gap_pct;
	int unsigned rx_stall_pct;
	int unsigned rx_hold;

	fenwick_range_sum_table_top #(
		.MAX_POSITIONS(POSITIONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.first_index(first_index),
		.end_index(end_index),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.range_total(range_total),
		.index_error(index_error)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("fenwick_range_sum_table_top test failed");
			$finish;
		end
	end

	// mostly short pauses, now and then a long one
	function automatic int unsigned pick_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic int unsigned pick_gap(input int unsigned pct);
		if ($urandom_range(99) < pct)
			return pick_len();
		return 0;
	endfunction

	function automatic int unsigned eff_size();
		return (cur_size > POSITIONS) ? POSITIONS : int'(cur_size);
	endfunction

	function automatic logic [SUM_W-1:0] prefix_sum(input int unsigned upto);
		logic [SUM_W-1:0] acc;
		int unsigned i;
		acc = '0;
		i = upto;
		while (i > 0 && i <= POSITIONS) begin
			acc += fen_sums[i];
			i -= i & (~i + 1);
		end
		return acc;
	endfunction

	function automatic void clear_sums();
		for (int unsigned j = 1; j <= POSITIONS; j++)
			fen_sums[j] = '0;
	endfunction

	// applies one accepted item to the local tree and queues the result it must give
	function automatic void update_sums_and_predict(input fen_item_t it);
		sum_result_t r;
		int unsigned n;
		int unsigned i;
		logic [SUM_W-1:0] amt64;
		n = eff_size();
		r = '0;
		amt64 = {{(SUM_W-32){it.amt[31]}}, it.amt};
		case (it.act)
			ACT_ADD: begin
				if (it.pos >= 1 && it.pos <= n) begin
					i = it.pos;
					while (i >= 1 && i <= n) begin
						fen_sums[i] += amt64;
						i += i & (~i + 1);
					end
				end else begin
					r.err = 1'b1;
				end
			end
			ACT_QUERY: begin
				if (it.pos >= 1 && it.pos <= it.end_pos && it.end_pos <= n + 1)
					r.total = prefix_sum(it.end_pos - 1) - prefix_sum(it.pos - 1);
				else
					r.err = 1'b1;
			end
			ACT_CLEAR: clear_sums();
			default: ;
		endcase
		pending_sums.push_back(r);
	endfunction

	function automatic fen_item_t mk(input frst_action_t act, input int unsigned p,
			input int unsigned e, input logic [31:0] v);
		fen_item_t it;
		it.act = act;
		it.pos = p[IDX_W-1:0];
		it.end_pos = e[IDX_W-1:0];
		it.amt = v;
		return it;
	endfunction

	function automatic logic [31:0] rand_amount();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 15) - 8;
			default: return $urandom;
		endcase
	endfunction

	// mostly well-formed adds and queries inside the active size, some noise and clears
	function automatic fen_item_t rand_item();
		int unsigned n;
		int unsigned r;
		int unsigned p;
		n = eff_size();
		r = $urandom_range(99);
		if (r < 45 && n != 0)
			return mk(ACT_ADD, $urandom_range(1, n), $urandom, rand_amount());
		if (r < 85) begin
			p = $urandom_range(1, n + 1);
			return mk(ACT_QUERY, p, $urandom_range(p, n + 1), $urandom);
		end
		if (r < 98)
			return mk(frst_action_t'($urandom_range(3)), $urandom_range(2047),
				$urandom_range(2047), $urandom);
		return mk(ACT_CLEAR, $urandom, $urandom, $urandom);
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < 10)
			$display("%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_sums.size() == 0) begin
				flag_mismatch($sformatf("unexpected result beat: total %0d error %0b",
					range_total, index_error));
			end else begin
				exp_sum = pending_sums.pop_front();
				if (range_total !== exp_sum.total || index_error !== exp_sum.err)
					flag_mismatch($sformatf(
						"result mismatch: total exp %0d got %0d, error exp %0b got %0b",
						$signed(exp_sum.total), range_total, exp_sum.err, index_error));
			end
		end
	end

	// receiver side stalls
	always @(negedge clk) begin
		if (rx_hold != 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else if ($urandom_range(99) < rx_stall_pct) begin
			out_ready <= 1'b0;
			rx_hold = pick_len() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// valid stays high across back-to-back beats
	task automatic send_item(input fen_item_t it);
		int unsigned gap;
		gap = pick_gap(tx_gap_pct);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action <= it.act;
		first_index <= it.pos;
		end_index <= it.end_pos;
		value <= it.amt;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		update_sums_and_predict(it);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] sz);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= sz;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_size = sz;
	endtask

	task automatic run_phase(input logic [SIZE_W-1:0] sz, input bit with_clear,
			input int unsigned count, input int unsigned tx, input int unsigned rx);
		wait_idle();
		write_size(sz);
		tx_gap_pct = tx;
		rx_stall_pct = rx;
		if (with_clear)
			send_item(mk(ACT_CLEAR, $urandom, $urandom, $urandom));
		for (int unsigned k = 0; k < count; k++)
			send_item(rand_item());
	endtask

	// full size after reset: field extremes, every action, every index rule
	task automatic test_directed_edges();
		tx_gap_pct = 20;
		rx_stall_pct = 20;
		send_item(mk(ACT_ADD, 1, 0, 32'h7fff_ffff));
		send_item(mk(ACT_ADD, 1024, 2047, 32'h8000_0000));
		send_item(mk(ACT_ADD, 512, 0, 32'hffff_ffff));
		send_item(mk(ACT_ADD, 0, 5, 32'h1234_5678));
		send_item(mk(ACT_ADD, 1025, 0, 32'h1));
		send_item(mk(ACT_ADD, 2047, 2047, $urandom));
		send_item(mk(ACT_QUERY, 1, 1025, 32'hffff_ffff));
		send_item(mk(ACT_QUERY, 1, 1, 0));
		send_item(mk(ACT_QUERY, 1025, 1025, 0));
		send_item(mk(ACT_QUERY, 1024, 1025, 0));
		send_item(mk(ACT_QUERY, 2, 1024, 0));
		send_item(mk(ACT_QUERY, 5, 3, 0));
		send_item(mk(ACT_QUERY, 0, 5, 0));
		send_item(mk(ACT_QUERY, 1, 1026, 0));
		send_item(mk(ACT_QUERY, 2047, 2047, 0));
		send_item(mk(ACT_NONE, 1, 1025, 32'h7fff_ffff));
		send_item(mk(ACT_NONE, 0, 0, 0));
		send_item(mk(ACT_QUERY, 512, 513, 0));
		send_item(mk(ACT_CLEAR, 2047, 2047, 32'hffff_ffff));
		send_item(mk(ACT_QUERY, 1, 1025, 0));
	endtask

	task automatic test_small_sizes();
		run_phase(1, 1'b1, 40, 30, 30);
		run_phase(2, 1'b1, 40, 0, 0);
		run_phase(3, 1'b1, 40, 50, 10);
	endtask

	// zero positions, saturation above the table depth, one below full
	task automatic test_size_extremes();
		run_phase(0, 1'b1, 30, 20, 20);
		run_phase(2047, 1'b1, 150, 10, 40);
		run_phase(1023, 1'b1, 100, 40, 0);
	endtask

	// size written without a following clear: stale entries stay in place
	task automatic test_resize_without_clear();
		run_phase(16, 1'b1, 40, 20, 20);
		run_phase(9, 1'b0, 40, 0, 30);
		run_phase(1024, 1'b0, 40, 30, 0);
	endtask

	task automatic test_random_sizes();
		logic [SIZE_W-1:0] sz;
		for (int unsigned p = 0; p < 8; p++) begin
			sz = SIZE_W'(($urandom_range(9) < 6) ? $urandom_range(1, 40)
				: $urandom_range(41, 1024));
			if (p % 3 == 0)
				run_phase(sz, $urandom_range(3) != 0, 54, 0, 0);
			else
				run_phase(sz, $urandom_range(3) != 0, 54, $urandom_range(10, 60),
					$urandom_range(10, 60));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		action = ACT_NONE;
		first_index = '0;
		end_index = '0;
		value = '0;
		out_ready = 1'b0;
		mismatches = 0;
		cycles = 0;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		rx_hold = 0;
		cur_size = ACTIVE_SIZE_RESET;
		clear_sums();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// the table clears itself after reset
		do @(posedge clk); while (!in_ready);

		test_directed_edges();
		test_small_sizes();
		test_size_extremes();
		test_resize_without_clear();
		test_random_sizes();

		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_sums.size() == 0)
			$display("fenwick_range_sum_table_top test passed");
		else
			$display("fenwick_range_sum_table_top test failed");
		$finish;
	end

endmodule
